// ===== rtl/ptcs_pkg.sv =====
// ptcs_pkg: types, constants and helpers for the photon trigger cut selector
// no dependencies; used by the channel interfaces and the top level
package ptcs_pkg;

	// number of eta edges supported; bins are edges minus one
	localparam int MAX_EDGES = 8;
	localparam int NUM_BINS  = MAX_EDGES - 1;

	// field types
	typedef logic signed [13:0] eta_t;
	typedef logic signed [14:0] phi_t;
	typedef logic        [15:0] et_t;
	typedef logic        [2:0]  bin_t;
	typedef logic        [2:0]  stage_cnt_t;
	typedef logic        [15:0] word16_t;
	typedef logic        [2:0]  reg_idx_t;
	typedef logic        [63:0] reg_data_t;

	// register indexes on the configuration channel
	localparam reg_idx_t REG_DETA_WINDOW   = 3'd0;
	localparam reg_idx_t REG_DPHI_WINDOW   = 3'd1;
	localparam reg_idx_t REG_SKIP_ID       = 3'd2;
	localparam reg_idx_t REG_EDGE_COUNT    = 3'd3;
	localparam reg_idx_t REG_EDGES_LO      = 3'd4;
	localparam reg_idx_t REG_EDGES_HI      = 3'd5;
	localparam reg_idx_t REG_THRESHOLDS_LO = 3'd6;
	localparam reg_idx_t REG_THRESHOLDS_HI = 3'd7;

	// register reset values
	localparam logic [12:0] DETA_WINDOW_RST = 13'd102;
	localparam logic [13:0] DPHI_WINDOW_RST = 14'd102;

	// fixed-point constants: fiducial 2.6, pi and 2*pi
	localparam logic [13:0]        FID_ETA_LIMIT = 14'd2662;
	localparam logic [16:0]        PI_FX         = 17'd12868;
	localparam logic signed [17:0] TWO_PI_FX     = 18'sd25736;

	// eta bin code for no bin found
	localparam bin_t NO_BIN = 3'd7;

	// stage counts
	localparam stage_cnt_t STAGES_NONE = 3'd0;
	localparam stage_cnt_t STAGES_DETA = 3'd1;
	localparam stage_cnt_t STAGES_DPHI = 3'd2;
	localparam stage_cnt_t STAGES_BIN  = 3'd3;
	localparam stage_cnt_t STAGES_ALL  = 3'd4;

	// 16-bit lane k of a pair of packed words, lanes 0..3 low, 4..7 high
	function automatic word16_t pick16(input logic [63:0] lo, input logic [63:0] hi,
			input int k);
		logic [63:0] w;
		w = (k < 4) ? lo : hi;
		return w[16*(k%4) +: 16];
	endfunction

endpackage

// ===== rtl/ptcs_if.sv =====
// ptcs channel interfaces: candidate input, result output, register writes
// depends on ptcs_pkg for the field types

interface ptcs_cand_if;
	import ptcs_pkg::*;
	logic valid;
	logic ready;
	eta_t roi_eta;
	phi_t roi_phi;
	eta_t cluster_eta;
	phi_t cluster_phi;
	et_t  cluster_et;
	logic id_flag;
	logic prior_passed;

	modport source (output valid, roi_eta, roi_phi, cluster_eta, cluster_phi,
		cluster_et, id_flag, prior_passed, input ready);
	modport sink (input valid, roi_eta, roi_phi, cluster_eta, cluster_phi,
		cluster_et, id_flag, prior_passed, output ready);
endinterface

interface ptcs_res_if;
	import ptcs_pkg::*;
	logic       valid;
	logic       ready;
	logic       accepted;
	stage_cnt_t stages_passed;
	bin_t       eta_bin;

	modport source (output valid, accepted, stages_passed, eta_bin, input ready);
	modport sink (input valid, accepted, stages_passed, eta_bin, output ready);
endinterface

interface ptcs_cfg_if;
	import ptcs_pkg::*;
	logic      valid;
	logic      ready;
	reg_idx_t  index;
	reg_data_t data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/photon_trigger_cut_selector_unit.sv =====
// photon trigger cut selector: three pipeline stages plus the output register
// lie between a candidate transfer and its result on res; throughput one
// candidate per cycle while res takes results; each stage advances when its
// successor has room, so bubbles are squeezed out and a stalled result holds
// in place; arst_n clears all valid bits and resets the config registers
// depends on ptcs_pkg and the channel interfaces in ptcs_if

module photon_trigger_cut_selector_unit (
	input logic        clk,
	input logic        arst_n,
	ptcs_cand_if.sink  cand,
	ptcs_res_if.source res,
	ptcs_cfg_if.sink   cfg
);
	import ptcs_pkg::*;

	// configuration registers
	logic [12:0] deta_window_q;
	logic [13:0] dphi_window_q;
	logic        skip_id_q;
	logic [3:0]  edge_count_q;
	logic [63:0] edges_lo_q;
	logic [63:0] edges_hi_q;
	logic [63:0] thr_lo_q;
	logic [47:0] thr_hi_q;

	// stage enables
	logic en_s1, en_s2, en_s3, en_o;

	// stage 1
	logic                v_s1;
	logic [13:0]         abs_roi_eta_s1;
	logic [13:0]         abs_cl_eta_s1;
	logic [14:0]         abs_deta_s1;
	logic signed [16:0]  phi_ref_s1;
	phi_t                cl_phi_s1;
	et_t                 et_s1;
	logic                id_s1;
	logic                prior_s1;

	// stage 2
	logic                v_s2;
	logic                fid_ok_s2;
	logic                deta_ok_s2;
	logic [16:0]         abs_dphi_s2;
	logic [NUM_BINS-1:0] in_bin_s2;
	et_t                 et_s2;
	logic                id_s2;

	// stage 3
	logic                v_s3;
	logic                fid_ok_s3;
	logic                deta_ok_s3;
	logic                dphi_ok_s3;
	bin_t                bin_s3;
	word16_t             thr_s3;
	et_t                 et_s3;
	logic                id_s3;

	// output register
	logic       v_o;
	logic       acc_o;
	stage_cnt_t stages_o;
	bin_t       bin_o;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deta_window_q <= DETA_WINDOW_RST;
			dphi_window_q <= DPHI_WINDOW_RST;
			skip_id_q     <= 1'b0;
			edge_count_q  <= '0;
			edges_lo_q    <= '0;
			edges_hi_q    <= '0;
			thr_lo_q      <= '0;
			thr_hi_q      <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DETA_WINDOW:   deta_window_q <= cfg.data[12:0];
				REG_DPHI_WINDOW:   dphi_window_q <= cfg.data[13:0];
				REG_SKIP_ID:       skip_id_q     <= cfg.data[0];
				REG_EDGE_COUNT:    edge_count_q  <= cfg.data[3:0];
				REG_EDGES_LO:      edges_lo_q    <= cfg.data;
				REG_EDGES_HI:      edges_hi_q    <= cfg.data;
				REG_THRESHOLDS_LO: thr_lo_q      <= cfg.data;
				REG_THRESHOLDS_HI: thr_hi_q      <= cfg.data[47:0];
				default: ;
			endcase
		end
	end

	// backpressure: a stage moves when empty or when its successor moves
	assign en_o  = !v_o  || res.ready;
	assign en_s3 = !v_s3 || en_o;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign cand.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_o  <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= cand.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_o)  v_o  <= v_s3;
		end
	end

	// stage 1: magnitudes, eta difference and roi phi fold
	logic signed [14:0] roi_eta_x, cl_eta_x, deta_x;
	logic signed [16:0] roi_phi_x;
	logic [14:0]        abs_roi_phi;

	always_comb begin
		roi_eta_x   = {cand.roi_eta[13], cand.roi_eta};
		cl_eta_x    = {cand.cluster_eta[13], cand.cluster_eta};
		deta_x      = cl_eta_x - roi_eta_x;
		roi_phi_x   = {{2{cand.roi_phi[14]}}, cand.roi_phi};
		abs_roi_phi = roi_phi_x[16] ? 15'(-roi_phi_x) : 15'(roi_phi_x);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			abs_roi_eta_s1 <= roi_eta_x[14] ? 14'(-roi_eta_x) : 14'(roi_eta_x);
			abs_cl_eta_s1  <= cl_eta_x[14] ? 14'(-cl_eta_x) : 14'(cl_eta_x);
			abs_deta_s1    <= deta_x[14] ? 15'(-deta_x) : 15'(deta_x);
			phi_ref_s1     <= ({2'b00, abs_roi_phi} > PI_FX)
				? 17'(roi_phi_x - 17'(TWO_PI_FX)) : roi_phi_x;
			cl_phi_s1      <= cand.cluster_phi;
			et_s1          <= cand.cluster_et;
			id_s1          <= cand.id_flag;
			prior_s1       <= cand.prior_passed;
		end
	end

	// stage 2: fiducial and deta cuts, phi difference, edge compares
	word16_t            edge_w [MAX_EDGES];
	logic [3:0]         n_edges;
	logic signed [17:0] dphi_x;
	logic [NUM_BINS-1:0] in_bin;

	always_comb begin
		n_edges = (edge_count_q > 4'(MAX_EDGES)) ? 4'(MAX_EDGES) : edge_count_q;
		for (int k = 0; k < MAX_EDGES; k++) begin
			edge_w[k] = pick16(edges_lo_q, edges_hi_q, k);
		end
		for (int i = 0; i < NUM_BINS; i++) begin
			in_bin[i] = ({2'b00, abs_cl_eta_s1} > edge_w[i])
				&& ({2'b00, abs_cl_eta_s1} < edge_w[i+1])
				&& (4'(i + 1) < n_edges);
		end
		dphi_x = {{3{cl_phi_s1[14]}}, cl_phi_s1} - {phi_ref_s1[16], phi_ref_s1};
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			fid_ok_s2   <= prior_s1 && (abs_roi_eta_s1 <= FID_ETA_LIMIT);
			deta_ok_s2  <= abs_deta_s1 <= {2'b00, deta_window_q};
			abs_dphi_s2 <= dphi_x[17] ? 17'(-dphi_x) : 17'(dphi_x);
			in_bin_s2   <= in_bin;
			et_s2       <= et_s1;
			id_s2       <= id_s1;
		end
	end

	// stage 3: phi wrap and window, bin priority, threshold select
	logic signed [17:0] dphi_wrap;
	logic               dphi_ok;
	bin_t               bin_sel;

	always_comb begin
		dphi_wrap = TWO_PI_FX - $signed({1'b0, abs_dphi_s2});
		if (abs_dphi_s2 < PI_FX) begin
			dphi_ok = abs_dphi_s2 <= {3'b000, dphi_window_q};
		end else begin
			dphi_ok = dphi_wrap[17] || (dphi_wrap[16:0] <= {3'b000, dphi_window_q});
		end
		bin_sel = NO_BIN;
		for (int i = NUM_BINS - 1; i >= 0; i--) begin
			if (in_bin_s2[i]) bin_sel = 3'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			fid_ok_s3  <= fid_ok_s2;
			deta_ok_s3 <= deta_ok_s2;
			dphi_ok_s3 <= dphi_ok;
			bin_s3     <= bin_sel;
			thr_s3     <= pick16(thr_lo_q, {16'h0000, thr_hi_q}, int'(bin_sel));
			et_s3      <= et_s2;
			id_s3      <= id_s2;
		end
	end

	// output stage: ET cut and final decision
	logic       acc_c;
	stage_cnt_t stages_c;

	always_comb begin
		acc_c    = 1'b0;
		stages_c = STAGES_NONE;
		if (fid_ok_s3 && deta_ok_s3) begin
			stages_c = STAGES_DETA;
			if (dphi_ok_s3) begin
				stages_c = STAGES_DPHI;
				if (bin_s3 != NO_BIN) begin
					stages_c = STAGES_BIN;
					if (et_s3 >= thr_s3) begin
						stages_c = STAGES_ALL;
						acc_c    = skip_id_q || id_s3;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			acc_o    <= acc_c;
			stages_o <= stages_c;
			bin_o    <= bin_s3;
		end
	end

	assign res.valid         = v_o;
	assign res.accepted      = acc_o;
	assign res.stages_passed = stages_o;
	assign res.eta_bin       = bin_o;

	// checks
	a_acc_all_stages: assert property (@(posedge clk) disable iff (!arst_n)
		v_o && acc_o |-> stages_o == STAGES_ALL)
		else $error("accepted result without all cut stages");

	a_bin_needed: assert property (@(posedge clk) disable iff (!arst_n)
		v_o && (stages_o == STAGES_BIN || stages_o == STAGES_ALL) |-> bin_o != NO_BIN)
		else $error("bin stage passed with no eta bin");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en_o |=> v_s3 && $stable(bin_s3) && $stable(thr_s3))
		else $error("stage 3 item changed while stalled");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en_s2 |=> v_s1 && $stable(et_s1) && $stable(prior_s1))
		else $error("stage 1 item lost under stall");

endmodule

// ===== tb/tb_photon_trigger_cut_selector_unit.sv =====
// testbench for photon_trigger_cut_selector_unit: directed and random candidates,
// each decision predicted on transfer and compared field by field on the result side
// depends on ptcs_pkg, the channel interfaces in ptcs_if and the top level
`timescale 1ns / 1ps

module tb_photon_trigger_cut_selector_unit;
	import ptcs_pkg::*;

	// fixed-point constants as plain integers so every compare is signed
	localparam int FID_LIM = int'(FID_ETA_LIMIT);
	localparam int PI_Q    = int'(PI_FX);
	localparam int TWO_PI_Q = int'(TWO_PI_FX);

	typedef struct {
		eta_t roi_eta;
		phi_t roi_phi;
		eta_t cl_eta;
		phi_t cl_phi;
		et_t  et;
		logic id_flag;
		logic prior;
	} cand_t;

	typedef struct {
		logic       accepted;
		stage_cnt_t stages;
		bin_t       bin;
	} decision_t;

	typedef struct {
		reg_idx_t  index;
		reg_data_t data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n;

	ptcs_cand_if cand_ch();
	ptcs_res_if  res_ch();
	ptcs_cfg_if  cfg_ch();

	photon_trigger_cut_selector_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// local copy of the register file, updated on each register transfer
	logic [12:0] deta_win = DETA_WINDOW_RST;
	logic [13:0] dphi_win = DPHI_WINDOW_RST;
	logic        skip_id  = 1'b0;
	logic [3:0]  edge_cnt = 4'd0;
	logic [63:0] edges_lo = '0;
	logic [63:0] edges_hi = '0;
	logic [63:0] thr_lo   = '0;
	logic [47:0] thr_hi   = '0;

	cand_t      candidate_queue[$];
	decision_t  decision_queue[$];
	reg_write_t reg_write_queue[$];

	int fail_count = 0;
	int tx_mode = 0;
	int rx_mode = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_left = 0;
	int cyc = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic int mag(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clip(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int spread(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int edge_at(input int k);
		logic [127:0] all_edges;
		all_edges = {edges_hi, edges_lo};
		return int'(all_edges[16*k +: 16]);
	endfunction

	function automatic int threshold_at(input int b);
		logic [111:0] all_thr;
		all_thr = {thr_hi, thr_lo};
		return int'(all_thr[16*b +: 16]);
	endfunction

	function automatic int edges_in_use();
		return (int'(edge_cnt) > MAX_EDGES) ? MAX_EDGES : int'(edge_cnt);
	endfunction

	// expected decision for one candidate under the current registers
	function automatic decision_t predict_decision(input cand_t c);
		decision_t d;
		int abs_cl;
		int phi_ref;
		int dphi;
		int n;
		d.accepted = 1'b0;
		d.stages   = STAGES_NONE;
		d.bin      = NO_BIN;
		abs_cl = mag(int'(c.cl_eta));
		n = edges_in_use();
		// first bin with strict edges on both sides
		for (int i = 0; i + 1 < n; i++) begin
			if (d.bin == NO_BIN && edge_at(i) < abs_cl && abs_cl < edge_at(i + 1))
				d.bin = bin_t'(i);
		end
		if (c.prior && mag(int'(c.roi_eta)) <= FID_LIM) begin
			// fold roi phi, then wrap the difference around 2*pi
			phi_ref = int'(c.roi_phi);
			if (mag(phi_ref) > PI_Q)
				phi_ref -= TWO_PI_Q;
			dphi = mag(int'(c.cl_phi) - phi_ref);
			if (dphi >= PI_Q)
				dphi = TWO_PI_Q - dphi;
			if (mag(int'(c.cl_eta) - int'(c.roi_eta)) <= int'(deta_win)) begin
				d.stages = STAGES_DETA;
				if (dphi <= int'(dphi_win)) begin
					d.stages = STAGES_DPHI;
					if (d.bin != NO_BIN) begin
						d.stages = STAGES_BIN;
						if (int'(c.et) >= threshold_at(int'(d.bin))) begin
							d.stages   = STAGES_ALL;
							d.accepted = skip_id ? 1'b1 : c.id_flag;
						end
					end
				end
			end
		end
		return d;
	endfunction

	// mostly candidates aimed at the windows, bins and thresholds; some pure noise
	function automatic cand_t random_candidate();
		cand_t c;
		int n;
		int b;
		int a;
		int lo;
		int hi;
		int ce;
		int rp;
		int wrap;
		n = edges_in_use();
		b = -1;
		if ($urandom_range(0, 9) < 2) begin
			c.roi_eta = 14'($urandom);
			c.roi_phi = 15'($urandom);
			c.cl_eta  = 14'($urandom);
			c.cl_phi  = 15'($urandom);
			c.et      = 16'($urandom);
			c.id_flag = 1'($urandom_range(0, 1));
			c.prior   = 1'($urandom_range(0, 1));
			return c;
		end
		if (n >= 2 && $urandom_range(0, 3) != 0) begin
			b  = $urandom_range(0, n - 2);
			lo = edge_at(b);
			hi = edge_at(b + 1);
			a  = (hi > lo) ? int'($urandom_range(lo, hi)) : lo;
		end else begin
			a = $urandom_range(0, 3000);
		end
		ce = clip($urandom_range(0, 1) ? -a : a, -8192, 8191);
		c.cl_eta  = 14'(ce);
		c.roi_eta = 14'(clip(ce + spread(int'(deta_win) + 2), -8192, 8191));
		rp = int'($urandom_range(0, 32767)) - 16384;
		case ($urandom_range(0, 3))
			0: wrap = TWO_PI_Q;
			1: wrap = -TWO_PI_Q;
			default: wrap = 0;
		endcase
		c.roi_phi = 15'(rp);
		c.cl_phi  = 15'(clip(rp + spread(int'(dphi_win) + 2) + wrap, -16384, 16383));
		if (b >= 0 && $urandom_range(0, 1))
			c.et = 16'(clip(threshold_at(b) + spread(3), 0, 65535));
		else
			c.et = 16'($urandom);
		c.id_flag = 1'($urandom_range(0, 1));
		c.prior   = ($urandom_range(0, 15) != 0);
		return c;
	endfunction

	// candidate driver: bursts and gaps, payload held until the transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_ch.valid        <= 1'b0;
			cand_ch.roi_eta      <= '0;
			cand_ch.roi_phi      <= '0;
			cand_ch.cluster_eta  <= '0;
			cand_ch.cluster_phi  <= '0;
			cand_ch.cluster_et   <= '0;
			cand_ch.id_flag      <= 1'b0;
			cand_ch.prior_passed <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (cand_ch.valid && cand_ch.ready) begin
				decision_queue.push_back(predict_decision(candidate_queue.pop_front()));
				if (tx_mode != 0) begin
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 8);
						gap_left = (tx_mode == 1) ? $urandom_range(0, 5) : $urandom_range(0, 20);
					end
				end
			end
			if (!(cand_ch.valid && !cand_ch.ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					cand_ch.valid <= 1'b0;
				end else if (candidate_queue.size() == 0) begin
					cand_ch.valid <= 1'b0;
				end else begin
					cand_ch.valid        <= 1'b1;
					cand_ch.roi_eta      <= candidate_queue[0].roi_eta;
					cand_ch.roi_phi      <= candidate_queue[0].roi_phi;
					cand_ch.cluster_eta  <= candidate_queue[0].cl_eta;
					cand_ch.cluster_phi  <= candidate_queue[0].cl_phi;
					cand_ch.cluster_et   <= candidate_queue[0].et;
					cand_ch.id_flag      <= candidate_queue[0].id_flag;
					cand_ch.prior_passed <= candidate_queue[0].prior;
				end
			end
		end
	end

	// register write driver, local copy follows each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= REG_DETA_WINDOW;
			cfg_ch.data  <= '0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (reg_write_queue[0].index)
					REG_DETA_WINDOW:   deta_win = reg_write_queue[0].data[12:0];
					REG_DPHI_WINDOW:   dphi_win = reg_write_queue[0].data[13:0];
					REG_SKIP_ID:       skip_id  = reg_write_queue[0].data[0];
					REG_EDGE_COUNT:    edge_cnt = reg_write_queue[0].data[3:0];
					REG_EDGES_LO:      edges_lo = reg_write_queue[0].data;
					REG_EDGES_HI:      edges_hi = reg_write_queue[0].data;
					REG_THRESHOLDS_LO: thr_lo   = reg_write_queue[0].data;
					REG_THRESHOLDS_HI: thr_hi   = reg_write_queue[0].data[47:0];
					default: ;
				endcase
				void'(reg_write_queue.pop_front());
			end
			if (reg_write_queue.size() != 0) begin
				cfg_ch.valid <= 1'b1;
				cfg_ch.index <= reg_write_queue[0].index;
				cfg_ch.data  <= reg_write_queue[0].data;
			end else begin
				cfg_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor with its own stall pattern
	always @(posedge clk or negedge arst_n) begin : res_monitor
		decision_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (decision_queue.size() == 0) begin
					report_error("result with no decision pending");
				end else begin
					want = decision_queue.pop_front();
					if (res_ch.accepted !== want.accepted)
						report_error($sformatf("accepted %b, predicted %b",
							res_ch.accepted, want.accepted));
					if (res_ch.stages_passed !== want.stages)
						report_error($sformatf("stages_passed %0d, predicted %0d",
							res_ch.stages_passed, want.stages));
					if (res_ch.eta_bin !== want.bin)
						report_error($sformatf("eta_bin %0d, predicted %0d",
							res_ch.eta_bin, want.bin));
				end
			end
			cyc++;
			case (rx_mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= ($urandom_range(0, 2) != 0);
				2: res_ch.ready <= ((cyc % 7) > 2);
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						res_ch.ready <= 1'b0;
					end else begin
						res_ch.ready <= 1'b1;
						if ($urandom_range(0, 9) == 0)
							stall_left = $urandom_range(1, 12);
					end
				end
			endcase
		end
	end

	task automatic write_reg(input reg_idx_t index, input reg_data_t data);
		reg_write_t w;
		w.index = index;
		w.data = data;
		reg_write_queue.push_back(w);
	endtask

	task automatic push_cand(input int re, input int rp, input int ce, input int cp,
			input int et, input int id, input int pr);
		cand_t c;
		c.roi_eta = 14'(re);
		c.roi_phi = 15'(rp);
		c.cl_eta  = 14'(ce);
		c.cl_phi  = 15'(cp);
		c.et      = 16'(et);
		c.id_flag = 1'(id);
		c.prior   = 1'(pr);
		candidate_queue.push_back(c);
	endtask

	task automatic push_random(input int count);
		for (int i = 0; i < count; i++)
			candidate_queue.push_back(random_candidate());
	endtask

	// everything sent, every decision back, no register write outstanding
	task automatic wait_idle();
		@(negedge clk);
		while (candidate_queue.size() != 0 || decision_queue.size() != 0 ||
				reg_write_queue.size() != 0 || cand_ch.valid || cfg_ch.valid)
			@(negedge clk);
	endtask

	task automatic pick_modes();
		tx_mode = $urandom_range(0, 2);
		rx_mode = $urandom_range(0, 3);
	endtask

	initial begin : stimulus
		logic [15:0] edge_val[8];
		int acc_edge;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers: no bins, prior reject, fiducial edge, phi fold and wrap
		pick_modes();
		push_cand(0, 0, 0, 0, 500, 1, 0);
		push_cand(2663, 0, 2663, 0, 500, 1, 1);
		push_cand(-2663, 0, -2663, 0, 500, 1, 1);
		push_cand(2662, 0, 2662, 0, 500, 1, 1);
		push_cand(-8192, -16384, -8192, -16384, 0, 0, 1);
		push_cand(0, 12869, 102, -12765, 100, 1, 1);
		push_cand(0, 0, 103, 0, 100, 1, 1);
		push_cand(0, 12800, 0, -12800, 100, 1, 1);
		push_cand(0, 12800, 0, -12900, 100, 1, 1);
		push_cand(8191, 16383, 8191, 16383, 65535, 1, 1);
		push_cand(100, -16384, 100, 16383, 65535, 1, 1);
		wait_idle();

		// realistic bins: strict edges, ET at and below threshold, id flag
		write_reg(REG_DETA_WINDOW, 64'd200);
		write_reg(REG_DPHI_WINDOW, 64'd300);
		write_reg(REG_SKIP_ID, 64'd0);
		write_reg(REG_EDGE_COUNT, 64'd5);
		write_reg(REG_EDGES_LO, {16'd2427, 16'd1536, 16'd1382, 16'd0});
		write_reg(REG_EDGES_HI, {16'd0, 16'd0, 16'd0, 16'd2560});
		write_reg(REG_THRESHOLDS_LO, {16'd350, 16'd300, 16'd250, 16'd200});
		write_reg(REG_THRESHOLDS_HI, 64'd0);
		wait_idle();
		tx_mode = 0;
		rx_mode = 0;
		push_cand(1382, 100, 1382, 100, 500, 1, 1);
		push_cand(1000, 100, 1000, 100, 200, 1, 1);
		push_cand(-1000, 100, -1000, 100, 199, 1, 1);
		push_cand(1400, 100, 1400, 100, 250, 0, 1);
		push_cand(2500, 100, 2500, 100, 350, 1, 1);
		push_cand(0, 100, 0, 100, 500, 1, 1);
		push_cand(2560, 100, 2560, 100, 500, 1, 1);
		push_random(100);
		wait_idle();

		// extremes: widest windows via oversized writes, clamped edge count, top thresholds
		pick_modes();
		write_reg(REG_DETA_WINDOW, '1);
		write_reg(REG_DPHI_WINDOW, '1);
		write_reg(REG_SKIP_ID, 64'd1);
		write_reg(REG_EDGE_COUNT, 64'd15);
		write_reg(REG_EDGES_LO, {16'd1500, 16'd1000, 16'd500, 16'd0});
		write_reg(REG_EDGES_HI, {16'hFFFF, 16'd4000, 16'd3000, 16'd2000});
		write_reg(REG_THRESHOLDS_LO, '1);
		write_reg(REG_THRESHOLDS_HI, '1);
		wait_idle();
		push_cand(2000, 100, 2000, 100, 65535, 0, 1);
		push_cand(2000, 100, 2000, 100, 65534, 0, 1);
		push_random(80);
		wait_idle();

		// narrowest windows, single edge so no bin at all
		pick_modes();
		write_reg(REG_DETA_WINDOW, 64'd0);
		write_reg(REG_DPHI_WINDOW, 64'd0);
		write_reg(REG_SKIP_ID, 64'd0);
		write_reg(REG_EDGE_COUNT, 64'd1);
		wait_idle();
		push_random(40);
		wait_idle();

		// fully random registers, edges not necessarily ascending
		for (int k = 0; k < 3; k++) begin
			pick_modes();
			write_reg(REG_DETA_WINDOW, {$urandom, $urandom});
			write_reg(REG_DPHI_WINDOW, {$urandom, $urandom});
			write_reg(REG_SKIP_ID, 64'($urandom_range(0, 1)));
			write_reg(REG_EDGE_COUNT, 64'($urandom_range(2, 8)));
			write_reg(REG_EDGES_LO, {$urandom, $urandom});
			write_reg(REG_EDGES_HI, {$urandom, $urandom});
			write_reg(REG_THRESHOLDS_LO, {$urandom, $urandom});
			write_reg(REG_THRESHOLDS_HI, {$urandom, $urandom});
			wait_idle();
			push_random(40);
			wait_idle();
		end

		// eight random ascending edges, moderate windows
		for (int k = 0; k < 8; k++) begin
			acc_edge = (k == 0) ? $urandom_range(0, 200) : acc_edge + $urandom_range(1, 1100);
			edge_val[k] = 16'(acc_edge);
		end
		pick_modes();
		write_reg(REG_DETA_WINDOW, 64'($urandom_range(50, 600)));
		write_reg(REG_DPHI_WINDOW, 64'($urandom_range(50, 600)));
		write_reg(REG_SKIP_ID, 64'($urandom_range(0, 1)));
		write_reg(REG_EDGE_COUNT, 64'd8);
		write_reg(REG_EDGES_LO, {edge_val[3], edge_val[2], edge_val[1], edge_val[0]});
		write_reg(REG_EDGES_HI, {edge_val[7], edge_val[6], edge_val[5], edge_val[4]});
		write_reg(REG_THRESHOLDS_LO, {$urandom_range(0, 800), $urandom_range(0, 800)} |
			({$urandom_range(0, 800), $urandom_range(0, 800)} << 16));
		write_reg(REG_THRESHOLDS_HI, {$urandom, $urandom} & 64'h0000_03FF_03FF_03FF);
		wait_idle();
		push_random(60);
		wait_idle();

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
